/* rtl/plob_pkg.sv */
`default_nettype none
package plob_pkg;

    localparam int PRICE_LEVELS_DEF   = 4096;
    localparam int ORDER_SLOTS_DEF    = 1024;
    localparam int LEVEL_QTY_BITS_DEF = 32;

    localparam logic [1:0] OP_ADD    = 2'd0;
    localparam logic [1:0] OP_CANCEL = 2'd1;
    localparam logic [1:0] OP_MODIFY = 2'd2;

    localparam logic SIDE_BUY = 1'b1;

    // one entry of the order table
    typedef struct packed {
        logic        valid;
        logic        side;
        logic [11:0] price;
        logic [15:0] qty;
    } t_ord_rec;

endpackage
`default_nettype wire

/* rtl/price_level_order_book.sv */
// book update: decode, then the old level is reduced (cancel, modify) and the new one raised
// (add, modify); then a search for the best bid and ask, up to PRICE_LEVELS levels per search and per fill
// throughput: one word at a time; no new word is taken until the walk over the level memories
// (one read port each) is done and any result has been taken
// reset: synchronous active low; a clearing pass over max(PRICE_LEVELS, ORDER_SLOTS) addresses
// then zeroes both level memories and the order table before the first word is taken
`default_nettype none
module price_level_order_book #(
    parameter int PRICE_LEVELS   = plob_pkg::PRICE_LEVELS_DEF,
    parameter int ORDER_SLOTS    = plob_pkg::ORDER_SLOTS_DEF,
    parameter int LEVEL_QTY_BITS = plob_pkg::LEVEL_QTY_BITS_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [1:0]  i_operation,
    input  wire logic [9:0]  i_order_id,
    input  wire logic        i_side,
    input  wire logic [11:0] i_price,
    input  wire logic [15:0] i_quantity,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [11:0]      o_best_bid,
    output logic [11:0]      o_best_ask,
    output logic [11:0]      o_spread,
    output logic [12:0]      o_mid_doubled
);

    localparam int PB   = $clog2(PRICE_LEVELS);
    localparam int OB   = $clog2(ORDER_SLOTS);
    localparam int QB   = LEVEL_QTY_BITS;
    localparam int MAXD = (PRICE_LEVELS > ORDER_SLOTS) ? PRICE_LEVELS : ORDER_SLOTS;
    localparam int CB   = $clog2(MAXD) + 1;
    localparam int RW   = $bits(plob_pkg::t_ord_rec);

    localparam logic [3:0] S_CLR    = 4'd0;
    localparam logic [3:0] S_IDLE   = 4'd1;
    localparam logic [3:0] S_DEC    = 4'd2;
    localparam logic [3:0] S_REM_WR = 4'd3;
    localparam logic [3:0] S_ADD_RD = 4'd4;
    localparam logic [3:0] S_ADD_WR = 4'd5;
    localparam logic [3:0] S_SC_RD  = 4'd6;
    localparam logic [3:0] S_SC_CK  = 4'd7;
    localparam logic [3:0] S_CROSS  = 4'd8;
    localparam logic [3:0] S_OUT    = 4'd9;

    logic [3:0]    r_state, n_state;
    logic [CB-1:0] r_cnt, n_cnt;

    // latched word
    logic [1:0]  r_op;
    logic [9:0]  r_id;
    logic        r_side;
    logic [11:0] r_price;
    logic [15:0] r_qty;

    // order being removed, and side used for the add
    logic        r_rside, n_rside;
    logic [11:0] r_rprice, n_rprice;
    logic [15:0] r_rqty, n_rqty;
    logic        r_lside, n_lside;

    // search and fill
    logic [PB-1:0] r_b, n_b, r_a, n_a;
    logic [QB-1:0] r_bq, n_bq, r_aq, n_aq;
    logic          r_bs, n_bs, r_as, n_as, r_bok, n_bok, r_aok, n_aok;

    logic [11:0] r_best_bid, n_best_bid, r_best_ask, n_best_ask, r_spread, n_spread;
    logic [12:0] r_mid, n_mid;

    // memory ports
    logic          bid_we, ask_we, ord_we;
    logic [PB-1:0] bid_waddr, ask_waddr, bid_raddr, ask_raddr;
    logic [QB-1:0] bid_wdata, ask_wdata, bid_q, ask_q;
    logic [OB-1:0] ord_waddr, ord_raddr;
    logic [RW-1:0] ord_wdata, ord_q;
    plob_pkg::t_ord_rec rec_q, rec_w;

    logic          id_ok, price_ok, go_scan;
    logic [QB-1:0] cur, cross_t, sub_b, sub_a;
    logic [QB:0]   sum;
    logic [PB:0]   mid_sum;

    plob_ram #(.WIDTH(QB), .DEPTH(PRICE_LEVELS)) u_bid (
        .i_clk(i_clk), .i_we(bid_we), .i_waddr(bid_waddr), .i_wdata(bid_wdata),
        .i_raddr(bid_raddr), .o_rdata(bid_q)
    );

    plob_ram #(.WIDTH(QB), .DEPTH(PRICE_LEVELS)) u_ask (
        .i_clk(i_clk), .i_we(ask_we), .i_waddr(ask_waddr), .i_wdata(ask_wdata),
        .i_raddr(ask_raddr), .o_rdata(ask_q)
    );

    plob_ram #(.WIDTH(RW), .DEPTH(ORDER_SLOTS)) u_ord (
        .i_clk(i_clk), .i_we(ord_we), .i_waddr(ord_waddr), .i_wdata(ord_wdata),
        .i_raddr(ord_raddr), .o_rdata(ord_q)
    );

    assign rec_q    = plob_pkg::t_ord_rec'(ord_q);
    assign ord_wdata = RW'(rec_w);
    assign id_ok    = 17'(r_id) < 17'(ORDER_SLOTS);
    assign price_ok = 17'(r_price) < 17'(PRICE_LEVELS);

    assign o_ready       = (r_state == S_IDLE);
    assign o_valid       = (r_state == S_OUT);
    assign o_best_bid    = r_best_bid;
    assign o_best_ask    = r_best_ask;
    assign o_spread      = r_spread;
    assign o_mid_doubled = r_mid;

    assign cur     = r_rside ? bid_q : ask_q;
    assign sum     = {1'b0, (r_lside ? bid_q : ask_q)} + (QB+1)'(r_qty);
    assign cross_t = (r_bq < r_aq) ? r_bq : r_aq;
    assign sub_b   = r_bq - cross_t;
    assign sub_a   = r_aq - cross_t;
    assign mid_sum = {1'b0, r_b} + {1'b0, r_a};

    always_comb begin
        n_state    = r_state;
        n_cnt      = r_cnt;
        n_rside    = r_rside;
        n_rprice   = r_rprice;
        n_rqty     = r_rqty;
        n_lside    = r_lside;
        n_b        = r_b;
        n_a        = r_a;
        n_bq       = r_bq;
        n_aq       = r_aq;
        n_bs       = r_bs;
        n_as       = r_as;
        n_bok      = r_bok;
        n_aok      = r_aok;
        n_best_bid = r_best_bid;
        n_best_ask = r_best_ask;
        n_spread   = r_spread;
        n_mid      = r_mid;
        go_scan    = 1'b0;

        bid_we    = 1'b0;
        ask_we    = 1'b0;
        ord_we    = 1'b0;
        bid_waddr = r_b;
        ask_waddr = r_a;
        bid_wdata = '0;
        ask_wdata = '0;
        bid_raddr = r_b;
        ask_raddr = r_a;
        ord_waddr = OB'(r_id);
        ord_raddr = OB'(i_order_id);
        rec_w     = '0;

        case (r_state)
            S_CLR: begin
                bid_waddr = PB'(r_cnt);
                ask_waddr = PB'(r_cnt);
                ord_waddr = OB'(r_cnt);
                bid_we    = r_cnt < CB'(PRICE_LEVELS);
                ask_we    = r_cnt < CB'(PRICE_LEVELS);
                ord_we    = r_cnt < CB'(ORDER_SLOTS);
                n_cnt     = r_cnt + 1'b1;
                if (r_cnt == CB'(MAXD - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_valid) begin
                    n_state = S_DEC;
                end
            end
            S_DEC: begin
                // level of the stored order, for a cancel or modify
                bid_raddr = PB'(rec_q.price);
                ask_raddr = PB'(rec_q.price);
                n_rside   = rec_q.side;
                n_rprice  = rec_q.price;
                n_rqty    = rec_q.qty;
                rec_w.valid = 1'b1;
                rec_w.price = r_price;
                rec_w.qty   = r_qty;
                case (r_op)
                    plob_pkg::OP_ADD: begin
                        if (id_ok && price_ok) begin
                            rec_w.side = r_side;
                            ord_we     = 1'b1;
                            n_lside    = r_side;
                            n_state    = S_ADD_RD;
                        end else begin
                            go_scan = 1'b1;
                        end
                    end
                    plob_pkg::OP_CANCEL: begin
                        if (id_ok && rec_q.valid) begin
                            rec_w   = '0;
                            ord_we  = 1'b1;
                            n_state = S_REM_WR;
                        end else begin
                            go_scan = 1'b1;
                        end
                    end
                    plob_pkg::OP_MODIFY: begin
                        if (id_ok && price_ok && rec_q.valid) begin
                            rec_w.side = rec_q.side;
                            ord_we     = 1'b1;
                            n_lside    = rec_q.side;
                            n_state    = S_REM_WR;
                        end else begin
                            go_scan = 1'b1;
                        end
                    end
                    default: begin
                        go_scan = 1'b1;
                    end
                endcase
            end
            S_REM_WR: begin
                // clamp at zero when fills already took part of the order
                bid_waddr = PB'(r_rprice);
                ask_waddr = PB'(r_rprice);
                bid_wdata = (cur >= QB'(r_rqty)) ? cur - QB'(r_rqty) : '0;
                ask_wdata = bid_wdata;
                bid_we    = r_rside;
                ask_we    = !r_rside;
                if (r_op == plob_pkg::OP_MODIFY) begin
                    n_state = S_ADD_RD;
                end else begin
                    go_scan = 1'b1;
                end
            end
            S_ADD_RD: begin
                bid_raddr = PB'(r_price);
                ask_raddr = PB'(r_price);
                n_state   = S_ADD_WR;
            end
            S_ADD_WR: begin
                bid_waddr = PB'(r_price);
                ask_waddr = PB'(r_price);
                bid_wdata = sum[QB] ? '1 : sum[QB-1:0];
                ask_wdata = bid_wdata;
                bid_we    = (r_lside == plob_pkg::SIDE_BUY);
                ask_we    = (r_lside != plob_pkg::SIDE_BUY);
                go_scan   = 1'b1;
            end
            S_SC_RD: begin
                n_state = S_SC_CK;
            end
            S_SC_CK: begin
                if (r_bs) begin
                    if (bid_q != '0) begin
                        n_bq  = bid_q;
                        n_bok = 1'b1;
                        n_bs  = 1'b0;
                    end else if (r_b == '0) begin
                        n_bs = 1'b0;
                    end else begin
                        n_b = r_b - 1'b1;
                    end
                end
                if (r_as) begin
                    if (ask_q != '0) begin
                        n_aq  = ask_q;
                        n_aok = 1'b1;
                        n_as  = 1'b0;
                    end else if (r_a == PB'(PRICE_LEVELS - 1)) begin
                        n_as = 1'b0;
                    end else begin
                        n_a = r_a + 1'b1;
                    end
                end
                if (n_bs || n_as) begin
                    n_state = S_SC_RD;
                end else if (n_bok && n_aok && r_b >= r_a) begin
                    n_state = S_CROSS;
                end else if (n_bok && n_aok) begin
                    n_best_bid = 12'(r_b);
                    n_best_ask = 12'(r_a);
                    n_spread   = 12'(r_a - r_b);
                    n_mid      = 13'(mid_sum);
                    n_state    = S_OUT;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_CROSS: begin
                // fill the smaller level against the other, rescan what emptied
                bid_wdata = sub_b;
                ask_wdata = sub_a;
                bid_we    = 1'b1;
                ask_we    = 1'b1;
                n_bq      = sub_b;
                n_aq      = sub_a;
                if (sub_b == '0) begin
                    n_bok = 1'b0;
                    if (r_b != '0) begin
                        n_b  = r_b - 1'b1;
                        n_bs = 1'b1;
                    end
                end
                if (sub_a == '0) begin
                    n_aok = 1'b0;
                    if (r_a != PB'(PRICE_LEVELS - 1)) begin
                        n_a  = r_a + 1'b1;
                        n_as = 1'b1;
                    end
                end
                n_state = (n_bs || n_as) ? S_SC_RD : S_IDLE;
            end
            S_OUT: begin
                if (i_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (go_scan) begin
            n_b     = PB'(PRICE_LEVELS - 1);
            n_a     = '0;
            n_bs    = 1'b1;
            n_as    = 1'b1;
            n_bok   = 1'b0;
            n_aok   = 1'b0;
            n_state = S_SC_RD;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
            r_cnt   <= '0;
            r_bs    <= 1'b0;
            r_as    <= 1'b0;
            r_bok   <= 1'b0;
            r_aok   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_bs    <= n_bs;
            r_as    <= n_as;
            r_bok   <= n_bok;
            r_aok   <= n_aok;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_valid) begin
            r_op    <= i_operation;
            r_id    <= i_order_id;
            r_side  <= i_side;
            r_price <= i_price;
            r_qty   <= i_quantity;
        end
        r_rside    <= n_rside;
        r_rprice   <= n_rprice;
        r_rqty     <= n_rqty;
        r_lside    <= n_lside;
        r_b        <= n_b;
        r_a        <= n_a;
        r_bq       <= n_bq;
        r_aq       <= n_aq;
        r_best_bid <= n_best_bid;
        r_best_ask <= n_best_ask;
        r_spread   <= n_spread;
        r_mid      <= n_mid;
    end

endmodule
`default_nettype wire

/* rtl/plob_ram.sv */
`default_nettype none
module plob_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

/* rtl/plob_chk.sv */
`default_nettype none
module plob_chk (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_valid,
    input wire logic        o_ready,
    input wire logic [1:0]  i_operation,
    input wire logic [9:0]  i_order_id,
    input wire logic        i_side,
    input wire logic [11:0] i_price,
    input wire logic [15:0] i_quantity,
    input wire logic        o_valid,
    input wire logic        i_ready,
    input wire logic [11:0] o_best_bid,
    input wire logic [11:0] o_best_ask,
    input wire logic [11:0] o_spread,
    input wire logic [12:0] o_mid_doubled
);

    // held result word: valid, best bid and best ask do not change
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_best_bid) && $stable(o_best_ask))
        else $error("result word changed while stalled");

    // spread and mid agree with the two prices, book never left crossed
    a_out_math: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_spread == o_best_ask - o_best_bid && o_spread != 12'd0 &&
                    o_mid_doubled == {1'b0, o_best_bid} + {1'b0, o_best_ask})
        else $error("result fields inconsistent");

    // one word in flight: no input taken while a result waits or right after one is taken
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid |-> !o_ready) and (i_valid && o_ready |=> !o_ready))
        else $error("input taken while busy");

    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && !o_ready)
        else $error("handshake active after reset");

endmodule

bind price_level_order_book plob_chk u_plob_chk (.*);
`default_nettype wire

/* bench/tb_price_level_order_book.sv */
`timescale 1ns / 100ps
`default_nettype none
module tb_price_level_order_book;
    import plob_pkg::*;

    localparam int          LEVELS     = PRICE_LEVELS_DEF;
    localparam int          SLOTS      = ORDER_SLOTS_DEF;
    localparam longint      LEVEL_FULL = (64'd1 << LEVEL_QTY_BITS_DEF) - 1;
    localparam logic [1:0]  OP_SPARE   = 2'd3;
    localparam int          MID_PRICE  = 2048;

    typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} t_idle;

    typedef struct {
        logic [11:0] bid;
        logic [11:0] ask;
        logic [11:0] spread;
        logic [12:0] mid2;
    } t_quote;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_ready;
    logic [1:0]  i_operation;
    logic [9:0]  i_order_id;
    logic        i_side;
    logic [11:0] i_price;
    logic [15:0] i_quantity;
    logic        o_valid;
    logic        i_ready;
    logic [11:0] o_best_bid;
    logic [11:0] o_best_ask;
    logic [11:0] o_spread;
    logic [12:0] o_mid_doubled;

    price_level_order_book u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_operation   (i_operation),
        .i_order_id    (i_order_id),
        .i_side        (i_side),
        .i_price       (i_price),
        .i_quantity    (i_quantity),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_best_bid    (o_best_bid),
        .o_best_ask    (o_best_ask),
        .o_spread      (o_spread),
        .o_mid_doubled (o_mid_doubled)
    );

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    // shadow book
    longint unsigned bid_qty [LEVELS];
    longint unsigned ask_qty [LEVELS];
    bit              ord_live [SLOTS];
    bit              ord_side [SLOTS];
    int              ord_price [SLOTS];
    int              ord_qty [SLOTS];

    t_quote quotes_due[$];
    t_idle  idle_mode;
    int     hold_left;
    int     errors;

    task automatic report_mismatch(input string what, input int want, input int got);
        $display("mismatch %s: expected %0d got %0d at %0t", what, want, got, $realtime);
        errors++;
    endtask

    task automatic level_put(input bit buy, input int px, input int qty);
        longint unsigned lv;
        lv = buy ? bid_qty[px] : ask_qty[px];
        lv = (longint'(qty) > LEVEL_FULL - lv) ? LEVEL_FULL : lv + qty;
        if (buy) bid_qty[px] = lv;
        else ask_qty[px] = lv;
    endtask

    task automatic pull_order(input int id);
        longint unsigned lv;
        lv = ord_side[id] ? bid_qty[ord_price[id]] : ask_qty[ord_price[id]];
        lv = (lv >= ord_qty[id]) ? lv - ord_qty[id] : 0;
        if (ord_side[id]) bid_qty[ord_price[id]] = lv;
        else ask_qty[ord_price[id]] = lv;
        ord_live[id] = 1'b0;
    endtask

    task automatic rest_order(input int id, input bit buy, input int px, input int qty);
        ord_side[id]  = buy;
        ord_price[id] = px;
        ord_qty[id]   = qty;
        ord_live[id]  = 1'b1;
        level_put(buy, px, qty);
    endtask

    function automatic int bid_below(input int from);
        while (from >= 0 && bid_qty[from] == 0) from--;
        return from;
    endfunction

    function automatic int ask_above(input int from);
        while (from < LEVELS && ask_qty[from] == 0) from++;
        return from;
    endfunction

    // apply one word to the shadow book, cross it and queue the quote if both sides rest
    task automatic book_update(input logic [1:0] op, input int id, input bit side,
                               input int px, input int qty);
        int b;
        int a;
        bit keep;
        longint unsigned fill;
        t_quote q;
        case (op)
            OP_ADD: rest_order(id, side, px, qty);
            OP_CANCEL: if (ord_live[id]) pull_order(id);
            OP_MODIFY: if (ord_live[id]) begin
                keep = ord_side[id];
                pull_order(id);
                rest_order(id, keep, px, qty);
            end
            default: ;
        endcase
        b = bid_below(LEVELS - 1);
        a = ask_above(0);
        while (b >= 0 && a < LEVELS && b >= a) begin
            fill = (bid_qty[b] < ask_qty[a]) ? bid_qty[b] : ask_qty[a];
            bid_qty[b] -= fill;
            ask_qty[a] -= fill;
            if (bid_qty[b] == 0) b = bid_below(b - 1);
            if (ask_qty[a] == 0) a = ask_above(a + 1);
        end
        if (b >= 0 && a < LEVELS) begin
            q.bid    = 12'(b);
            q.ask    = 12'(a);
            q.spread = 12'(a - b);
            q.mid2   = 13'(a + b);
            quotes_due.push_back(q);
        end
    endtask

    function automatic bit idle_roll(input bit sender);
        case (idle_mode)
            IDLE_SEND: return sender ? ($urandom_range(99) < 75) : 1'b0;
            IDLE_RECV: return sender ? 1'b0 : ($urandom_range(99) < 75);
            IDLE_BOTH: return $urandom_range(99) < 15;
            default:   return 1'b0;
        endcase
    endfunction

    // called at a falling edge; leaves valid high after acceptance
    task automatic send_word(input logic [1:0] op, input int id, input bit side,
                             input int px, input int qty);
        if (idle_roll(1'b1)) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge i_clk);
        end
        i_operation <= op;
        i_order_id  <= 10'(id);
        i_side      <= side;
        i_price     <= 12'(px);
        i_quantity  <= 16'(qty);
        i_valid     <= 1'b1;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        book_update(op, id, side, px, qty);
        @(negedge i_clk);
    endtask

    task automatic settle();
        i_valid <= 1'b0;
        wait (quotes_due.size() == 0);
        repeat (20000) @(negedge i_clk);
    endtask

    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            i_ready   <= 1'b0;
            hold_left <= hold_left - 1;
        end else begin
            i_ready <= !idle_roll(1'b0);
        end
    end

    always @(posedge i_clk) begin
        t_quote q;
        if (i_rst_n && o_valid && i_ready) begin
            if (quotes_due.size() == 0) begin
                report_mismatch("quote count", 0, 1);
            end else begin
                q = quotes_due.pop_front();
                if (o_best_bid !== q.bid) report_mismatch("best_bid", q.bid, o_best_bid);
                if (o_best_ask !== q.ask) report_mismatch("best_ask", q.ask, o_best_ask);
                if (o_spread !== q.spread) report_mismatch("spread", q.spread, o_spread);
                if (o_mid_doubled !== q.mid2)
                    report_mismatch("mid_doubled", q.mid2, o_mid_doubled);
            end
        end
    end

    task automatic test_directed();
        idle_mode = IDLE_NONE;
        send_word(OP_CANCEL, 5, 0, 0, 1);            // unknown id
        send_word(OP_MODIFY, 6, 1, 100, 7);          // unknown id
        send_word(OP_ADD, 0, SIDE_BUY, 0, 1);
        send_word(OP_ADD, 1023, 0, 4095, 65535);
        send_word(OP_SPARE, 1023, 1, 4095, 65535);
        send_word(OP_ADD, 2, SIDE_BUY, 4095, 65535); // sweeps whole ask
        send_word(OP_ADD, 3, 0, 4095, 10);
        send_word(OP_CANCEL, 1023, 0, 0, 1);         // level already filled, clamps
        send_word(OP_ADD, 4, SIDE_BUY, 2000, 500);
        send_word(OP_ADD, 5, 0, 2100, 300);
        send_word(OP_ADD, 4, SIDE_BUY, 2010, 50);    // reused id, old qty stays
        send_word(OP_MODIFY, 5, SIDE_BUY, 2050, 40); // stays an ask
        send_word(OP_MODIFY, 4, 0, 2060, 20);        // bid crosses ask
        send_word(OP_ADD, 6, 0, 2001, 1000);
        send_word(OP_CANCEL, 6, 1, 4095, 65535);
        send_word(OP_CANCEL, 0, 0, 0, 1);
        send_word(OP_ADD, 7, SIDE_BUY, 1, 1);
        send_word(OP_ADD, 8, 0, 2, 1);
        send_word(OP_CANCEL, 4, 0, 0, 1);
        send_word(OP_CANCEL, 5, 0, 0, 1);
        send_word(OP_CANCEL, 2, 0, 0, 1);
        send_word(OP_CANCEL, 3, 0, 0, 1);
        settle();
    endtask

    task automatic random_word();
        int roll;
        int id;
        bit buy;
        int px;
        roll = $urandom_range(99);
        id   = ($urandom_range(9) == 0) ? $urandom_range(SLOTS - 1) : $urandom_range(63);
        buy  = $urandom_range(1);
        px   = buy ? MID_PRICE - $urandom_range(40) + 3 : MID_PRICE + $urandom_range(40) - 3;
        if (roll < 8)
            send_word(2'($urandom_range(3)), $urandom_range(SLOTS - 1), $urandom_range(1),
                      $urandom_range(LEVELS - 1), $urandom_range(1, 65535));
        else if (roll < 55)
            send_word(OP_ADD, id, buy, px, $urandom_range(1, 2000));
        else if (roll < 75)
            send_word(OP_CANCEL, id, $urandom_range(1), $urandom_range(LEVELS - 1),
                      $urandom_range(1, 65535));
        else
            send_word(OP_MODIFY, id, $urandom_range(1), px, $urandom_range(1, 2000));
    endtask

    task automatic test_random(input t_idle mode, input int count);
        idle_mode = mode;
        repeat (count) random_word();
        settle();
    endtask

    task automatic test_backpressure();
        idle_mode = IDLE_NONE;
        hold_left = 4000;
        repeat (40) random_word();
        settle();
    endtask

    initial begin
        errors      = 0;
        hold_left   = 0;
        idle_mode   = IDLE_NONE;
        i_rst_n     = 1'b0;
        i_valid     = 1'b0;
        i_ready     = 1'b0;
        i_operation = OP_ADD;
        i_order_id  = '0;
        i_side      = 1'b0;
        i_price     = '0;
        i_quantity  = 16'd1;
        for (int k = 0; k < LEVELS; k++) begin
            bid_qty[k] = 0;
            ask_qty[k] = 0;
        end
        for (int k = 0; k < SLOTS; k++) ord_live[k] = 1'b0;
        repeat (12) @(negedge i_clk);
        i_rst_n = 1'b1;
        test_directed();
        test_random(IDLE_NONE, 220);
        test_random(IDLE_SEND, 200);
        test_random(IDLE_RECV, 200);
        test_random(IDLE_BOTH, 220);
        test_backpressure();
        if (errors == 0) $display("Simulation PASSED");
        else $display("Simulation FAILED");
        $finish;
    end

    initial begin
        #500_000_000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule
`default_nettype wire

/* sim.f */
rtl/plob_pkg.sv
rtl/plob_ram.sv
rtl/price_level_order_book.sv
rtl/plob_chk.sv
bench/tb_price_level_order_book.sv
